@@ hdl/bfps_pkg.sv @@
package bfps_pkg;

   // Default number of fraction bits of the bevel position (Q1.16).
   localparam int POS_FRAC_BITS_DEF = 16;

   // Flat alpha curve: linear below the split level, parabolic above it.
   localparam int SPLIT_LEVEL = 213;
   localparam int ALPHA_SCALE = 200;
   localparam int ALPHA_MIN   = 1;
   localparam int ALPHA_MAX   = 254;
   localparam int SPAN_SQ     = (255 - SPLIT_LEVEL) * (255 - SPLIT_LEVEL);

   // Mid grey targets of the blends.
   localparam logic [7:0] MID_HIGH = 8'd128;
   localparam logic [7:0] MID_LOW  = 8'd127;

   // Fill style codes. Code seven has no member and shades as flat.
   typedef enum logic [2:0] {
      STYLE_FLAT   = 3'd0,
      STYLE_ROUND  = 3'd1,
      STYLE_SQUARE = 3'd2,
      STYLE_FRAME  = 3'd3,
      STYLE_SMOOTH = 3'd4,
      STYLE_POINT  = 3'd5,
      STYLE_RUFFLE = 3'd6
   } style_type;

   // One shaded pixel, red in the lowest byte.
   typedef struct packed {
      logic [7:0] alpha;
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } pixel_type;

   typedef logic [7:0] alpha_lut_type [256];

   // Builds the flat alpha table at elaboration time.
   function automatic alpha_lut_type build_flat_alpha_lut();
      alpha_lut_type lut;
      int a;
      int d;
      for (int v = 0; v < 256; v++) begin
         if (v < SPLIT_LEVEL) begin
            a = (ALPHA_SCALE * v) / SPLIT_LEVEL;
         end else begin
            d = v - SPLIT_LEVEL;
            a = (ALPHA_SCALE * (SPAN_SQ - d * d)) / SPAN_SQ;
         end
         if (a > ALPHA_MAX) a = ALPHA_MAX;
         if (a < ALPHA_MIN) a = ALPHA_MIN;
         lut[v] = 8'(a);
      end
      return lut;
   endfunction

   localparam alpha_lut_type FLAT_ALPHA_LUT = build_flat_alpha_lut();

endpackage

@@ hdl/bfps_shade_core.sv @@
module bfps_shade_core
   import bfps_pkg::*;
#(
   parameter int POS_FRAC_BITS = POS_FRAC_BITS_DEF
) (
   input  logic [2:0]             style,
   input  logic [7:0]             level,
   input  logic [POS_FRAC_BITS:0] position,
   output pixel_type              pixel
);

   localparam int PW = POS_FRAC_BITS + 1;
   localparam int BW = POS_FRAC_BITS + 9;
   localparam int HW = POS_FRAC_BITS + 8;

   localparam logic [PW-1:0] ONE   = {1'b1, {POS_FRAC_BITS{1'b0}}};
   localparam logic [PW-1:0] HALF  = ONE >> 1;
   localparam logic [HW-1:0] ONE_H = HW'(ONE);
   localparam logic [HW-1:0] TH_3  = HW'(ONE_H * 3);
   localparam logic [HW-1:0] TH_7  = HW'(ONE_H * 7);
   localparam logic [HW-1:0] TH_15 = HW'(ONE_H * 15);
   localparam logic [HW-1:0] TH_30 = HW'(ONE_H * 30);
   localparam logic [HW-1:0] TH_45 = HW'(ONE_H * 45);
   localparam logic [HW-1:0] TH_60 = HW'(ONE_H * 60);
   localparam logic [HW-1:0] TH_80 = HW'(ONE_H * 80);

   logic [PW-1:0] pos_sat;
   logic [PW-1:0] pos_rest;
   logic [HW-1:0] pos_x10;
   logic [HW-1:0] pos_x100;
   logic [PW-1:0] round_q;
   logic [7:0]    round_c;
   logic [BW-1:0] round_num;
   logic [PW-1:0] blend_s;
   logic [BW-1:0] blend_num;
   logic [7:0]    round_k;
   logic [7:0]    blend_k;
   logic [7:0]    square_k;
   logic [7:0]    point_k;
   logic          ruffle_keep;
   logic [7:0]    ruffle_k;

   // Positions past one saturate to one.
   assign pos_sat  = (position > ONE) ? ONE : position;
   assign pos_rest = ONE - pos_sat;
   assign pos_x10  = HW'(HW'(pos_sat) * 10);
   assign pos_x100 = HW'(HW'(pos_sat) * 100);

   // Round blends from the level to mid grey, then from mid grey to the complement.
   always_comb begin
      if (pos_sat <= HALF) begin
         round_q = pos_sat << 1;
         round_c = level;
      end else begin
         round_q = pos_rest << 1;
         round_c = ~level;
      end
      round_num = BW'(round_c) * BW'(ONE - round_q) + (BW'(round_q) << 7);
   end
   assign round_k = round_num[POS_FRAC_BITS +: 8];

   // Frame and smooth share one blend, smooth runs it from the far side.
   always_comb begin
      blend_s = (style == STYLE_SMOOTH) ? pos_rest : pos_sat;
      if (level <= MID_HIGH) begin
         blend_num = (BW'(MID_HIGH) << POS_FRAC_BITS)
                     - BW'(MID_HIGH - level) * BW'(blend_s);
      end else begin
         blend_num = (BW'(MID_LOW) << POS_FRAC_BITS)
                     + BW'(level - MID_LOW) * BW'(blend_s);
      end
   end
   assign blend_k = blend_num[POS_FRAC_BITS +: 8];

   always_comb begin
      if (pos_x10 <= TH_3) begin
         square_k = level;
      end else if (pos_x10 >= TH_7) begin
         square_k = ~level;
      end else begin
         square_k = MID_HIGH;
      end
   end

   assign point_k = (pos_sat < HALF) ? level : ~level;

   // Ruffle keeps the level in three bands and inverts it in between and above the last.
   always_comb begin
      if (pos_x100 < TH_15) begin
         ruffle_keep = 1'b1;
      end else if (pos_x100 < TH_30) begin
         ruffle_keep = 1'b0;
      end else if (pos_x100 < TH_45) begin
         ruffle_keep = 1'b1;
      end else if (pos_x100 < TH_60) begin
         ruffle_keep = 1'b0;
      end else if (pos_x100 < TH_80) begin
         ruffle_keep = 1'b1;
      end else begin
         ruffle_keep = 1'b0;
      end
   end
   assign ruffle_k = ruffle_keep ? level : ~level;

   always_comb begin
      unique case (style)
         STYLE_ROUND: begin
            pixel = '{alpha: level, blue: round_k, green: round_k, red: round_k};
         end
         STYLE_SQUARE: begin
            pixel = '{alpha: level, blue: square_k, green: square_k, red: square_k};
         end
         STYLE_FRAME, STYLE_SMOOTH: begin
            pixel = '{alpha: blend_k, blue: blend_k, green: blend_k, red: blend_k};
         end
         STYLE_POINT: begin
            pixel = '{alpha: point_k, blue: point_k, green: point_k, red: point_k};
         end
         STYLE_RUFFLE: begin
            pixel = '{alpha: ruffle_k, blue: ruffle_k, green: ruffle_k, red: ruffle_k};
         end
         default: begin
            pixel = '{alpha: FLAT_ALPHA_LUT[level], blue: level, green: level, red: level};
         end
      endcase
   end

endmodule

@@ hdl/bevel_fill_pixel_shader.sv @@
// Bevel fill pixel shader: one RGBA pixel per request.
// The req channel carries a lighting level and a bevel position (unsigned,
// POS_FRAC_BITS fraction bits, where one is 1.0 and larger values saturate).
// The rsp channel returns red, green, blue and alpha bytes for each request,
// in request order. The csr channel writes the 3-bit fill style: flat, round,
// square, frame, smooth, point or ruffle; code seven shades as flat. The style
// should be written only while no request is in flight.
// An accepted request is held in the input register; rsp_tvalid rises when
// its result is loaded into the output register. There is one input
// register, then the shading logic into the output register. Throughput is
// one request per cycle while rsp_tready is high, set by one shading pass.
// If the receiver stalls, the result holds in the output register and one
// more request can still enter the input register; req_tready drops only
// when both registers are full. Reset clears both stages and sets the style
// to flat; csr_ready is always high.
module bevel_fill_pixel_shader
   import bfps_pkg::*;
#(
   parameter int  POS_FRAC_BITS = POS_FRAC_BITS_DEF,
   localparam int REQ_W         = ((POS_FRAC_BITS + 9 + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // Fields from bit 0 up: level (8), position (POS_FRAC_BITS + 1), zero pad.
   input  logic [REQ_W-1:0] req_tdata,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // Fields from bit 0 up: red (8), green (8), blue (8), alpha (8).
   output logic [31:0]      rsp_tdata,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [2:0]       csr_data
);

   localparam int PW = POS_FRAC_BITS + 1;

   logic [2:0]    style_ff, style_in;
   logic          s1_valid_ff, s1_valid_in;
   logic [7:0]    s1_level_ff, s1_level_in;
   logic [PW-1:0] s1_position_ff, s1_position_in;
   logic          rsp_valid_ff, rsp_valid_in;
   pixel_type     rsp_pixel_ff, rsp_pixel_in;
   pixel_type     shade_pixel;
   logic          out_ready;
   logic          req_accept;
   logic          s1_move;

   // The output register frees up when empty or when its result is taken,
   // and the input register frees up when empty or when it moves forward.
   assign out_ready  = !rsp_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || out_ready;
   assign req_accept = req_tvalid && req_tready;
   assign s1_move    = s1_valid_ff && out_ready;
   assign csr_ready  = 1'b1;

   always_comb begin
      style_in = style_ff;
      if (csr_valid) begin
         style_in = csr_data;
      end
   end

   always_comb begin
      s1_valid_in    = s1_valid_ff;
      s1_level_in    = s1_level_ff;
      s1_position_in = s1_position_ff;
      if (req_accept) begin
         s1_valid_in    = 1'b1;
         s1_level_in    = req_tdata[7:0];
         s1_position_in = req_tdata[8 +: PW];
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
   end

   bfps_shade_core #(
      .POS_FRAC_BITS(POS_FRAC_BITS)
   ) u_shade_core (
      .style   (style_ff),
      .level   (s1_level_ff),
      .position(s1_position_ff),
      .pixel   (shade_pixel)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_pixel_in = rsp_pixel_ff;
      if (out_ready) begin
         rsp_valid_in = s1_valid_ff;
         if (s1_valid_ff) begin
            rsp_pixel_in = shade_pixel;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         style_ff     <= STYLE_FLAT;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         style_ff     <= style_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_level_ff    <= s1_level_in;
      s1_position_ff <= s1_position_in;
      rsp_pixel_ff   <= rsp_pixel_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_pixel_ff;

endmodule

@@ hdl/bfps_checker.sv @@
module bfps_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);

   // Reset empties the output register.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   // A stalled result holds its data.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // An accepted request reaches the output register.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> ##1 rsp_tvalid)
      else $error("request did not reach the output");

   // With nothing waiting at the output, req_tready is always high.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("req_tready low with an empty output");

   // Every style shades red, green and blue alike.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[7:0] == rsp_tdata[15:8] && rsp_tdata[15:8] == rsp_tdata[23:16])
      else $error("color channels differ");

endmodule

bind bevel_fill_pixel_shader bfps_checker u_bfps_checker (.*);
